// File: rtl/idls_pkg.sv
// ----------------------------------------------------------------------------
// idls_pkg
// Shared types and constants of the invalid directive line scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package idls_pkg;

  // Result field widths
  localparam int unsigned OUT_OFFSET_W = 24;
  localparam int unsigned OUT_LEN_W    = 4;
  localparam int unsigned LEN_SAT      = 8;

  // Depth of the judgment queue between front and back
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Bytes of interest
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Scan phase, one-hot
  typedef enum logic [3:0] {
    PH_LINE_START = 4'b0001,
    PH_AFTER_HASH = 4'b0010,
    PH_NAME       = 4'b0100,
    PH_SKIP_LINE  = 4'b1000
  } scan_phase_e;

  // Standard directive names, first char in the low byte, zero padded
  localparam int unsigned NUM_DIRS  = 12;
  localparam int unsigned DIR_CHARS = 7;
  localparam int unsigned DIR_LEN_W = 3;

  typedef logic [DIR_CHARS*8-1:0] dir_name_t;

  localparam dir_name_t DIR_NAME [NUM_DIRS] = '{
    56'h00000000006669,  // if
    56'h00006665646669,  // ifdef
    56'h006665646E6669,  // ifndef
    56'h00000066696C65,  // elif
    56'h00000065736C65,  // else
    56'h00006669646E65,  // endif
    56'h6564756C636E69,  // include
    56'h00656E69666564,  // define
    56'h00006665646E75,  // undef
    56'h000000656E696C,  // line
    56'h0000726F727265,  // error
    56'h00616D67617270   // pragma
  };

  localparam logic [DIR_LEN_W-1:0] DIR_LEN [NUM_DIRS] = '{
    3'd2, 3'd5, 3'd6, 3'd4, 3'd4, 3'd5, 3'd7, 3'd6, 3'd5, 3'd4, 3'd5, 3'd6
  };

endpackage

`default_nettype wire

// File: rtl/idls_front.sv
// ----------------------------------------------------------------------------
// idls_front
// Byte scanner: tracks line phase, splices and offsets, gathers directive
// names and emits one judgment request when a name ends.
// ----------------------------------------------------------------------------
`default_nettype none

module idls_front #(
  parameter int unsigned OFFSET_BITS    = 24,
  parameter int unsigned MAX_NAME_CHARS = 7,
  parameter int unsigned CNT_W          = $clog2(MAX_NAME_CHARS + 2),
  parameter int unsigned ENTRY_W        = MAX_NAME_CHARS*8 + CNT_W + OFFSET_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,       // byte transfer this cycle
  input  wire logic [7:0]         byte_i,
  input  wire logic               start_i,
  input  wire logic               spliced_i,
  input  wire logic               end_i,
  output logic                    push_o,
  output logic [ENTRY_W-1:0]      entry_o         // chars, count, line offset
);

  localparam int unsigned NAME_W = MAX_NAME_CHARS*8;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  idls_pkg::scan_phase_e  phase_q, phase_d, phase_e;
  logic                   bs_q, bs_d, bs_e;
  logic                   bscr_q, bscr_d, bscr_e;
  logic [NAME_W-1:0]      chars_q, chars_d, chars_e;
  logic [CNT_W-1:0]       count_q, count_d, count_e;
  logic [OFFSET_BITS-1:0] lo_q, lo_d, lo_e;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_e;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic                   is_blank, is_name;
  logic                   judge_now;

  assign is_blank = (byte_i == idls_pkg::CH_SPACE) || (byte_i == idls_pkg::CH_TAB);
  assign is_name  = (byte_i >= 8'h41 && byte_i <= 8'h5A) ||
                    (byte_i >= 8'h61 && byte_i <= 8'h7A) ||
                    (byte_i == idls_pkg::CH_UNDER);

  // Next scanner state for the byte being transferred
  always_comb begin
    if (start_i) begin
      phase_e = spliced_i ? idls_pkg::PH_SKIP_LINE : idls_pkg::PH_LINE_START;
      bs_e    = 1'b0;
      bscr_e  = 1'b0;
      chars_e = '0;
      count_e = '0;
      lo_e    = '0;
      pos_e   = '0;
    end else begin
      phase_e = phase_q;
      bs_e    = bs_q;
      bscr_e  = bscr_q;
      chars_e = chars_q;
      count_e = count_q;
      lo_e    = lo_q;
      pos_e   = pos_q;
    end

    pos_inc   = (pos_e != OFF_MAX) ? pos_e + 1'b1 : pos_e;
    phase_d   = phase_e;
    chars_d   = chars_e;
    count_d   = count_e;
    lo_d      = lo_e;
    judge_now = 1'b0;

    unique case (phase_e)
      idls_pkg::PH_LINE_START: begin
        if (byte_i == idls_pkg::CH_HASH) begin
          phase_d = idls_pkg::PH_AFTER_HASH;
        end else if (!is_blank) begin
          phase_d = idls_pkg::PH_SKIP_LINE;
        end
      end
      idls_pkg::PH_AFTER_HASH: begin
        if (is_name) begin
          chars_d       = '0;
          chars_d[7:0]  = byte_i;
          count_d       = CNT_W'(1);
          phase_d       = idls_pkg::PH_NAME;
        end else if (!is_blank) begin
          phase_d = idls_pkg::PH_SKIP_LINE;
        end
      end
      idls_pkg::PH_NAME: begin
        if (is_name) begin
          for (int i = 0; i < MAX_NAME_CHARS; i++) begin
            if (count_e == CNT_W'(i)) chars_d[i*8 +: 8] = byte_i;
          end
          if (count_e < CNT_W'(MAX_NAME_CHARS + 1)) count_d = count_e + 1'b1;
        end else begin
          judge_now = 1'b1;
          phase_d   = idls_pkg::PH_SKIP_LINE;
        end
      end
      default: begin
        phase_d = idls_pkg::PH_SKIP_LINE;
      end
    endcase

    // Newline: next line starts, unless spliced
    if (byte_i == idls_pkg::CH_LF) begin
      phase_d = (bs_e || bscr_e) ? idls_pkg::PH_SKIP_LINE : idls_pkg::PH_LINE_START;
      lo_d    = pos_inc;
    end

    bscr_d = bs_e && (byte_i == idls_pkg::CH_CR);
    bs_d   = (byte_i == idls_pkg::CH_BSL);
    pos_d  = pos_inc;

    // Judgment request: name ended by a byte, or cut by the region end
    push_o  = accept_i && (judge_now || (end_i && phase_d == idls_pkg::PH_NAME));
    entry_o = {lo_e, count_d, chars_d};

    // Region end returns to reset state
    if (end_i) begin
      phase_d = idls_pkg::PH_LINE_START;
      bs_d    = 1'b0;
      bscr_d  = 1'b0;
      chars_d = '0;
      count_d = '0;
      lo_d    = '0;
      pos_d   = '0;
    end
  end

  // Scanner state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= idls_pkg::PH_LINE_START;
      bs_q    <= 1'b0;
      bscr_q  <= 1'b0;
      chars_q <= '0;
      count_q <= '0;
      lo_q    <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      bs_q    <= bs_d;
      bscr_q  <= bscr_d;
      chars_q <= chars_d;
      count_q <= count_d;
      lo_q    <= lo_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/idls_queue.sv
// ----------------------------------------------------------------------------
// idls_queue
// Short FIFO of judgment requests between scanner and matcher.
// ----------------------------------------------------------------------------
`default_nettype none

module idls_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  not_full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int unsigned DEPTH = idls_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign not_full_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign data_o     = mem_q[rd_q];
  assign do_push    = push_i && not_full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

// File: rtl/idls_back.sv
// ----------------------------------------------------------------------------
// idls_back
// Name matcher: checks a gathered name against the standard directives and
// holds a result in the output register when the name is invalid.
// ----------------------------------------------------------------------------
`default_nettype none

module idls_back #(
  parameter int unsigned OFFSET_BITS    = 24,
  parameter int unsigned MAX_NAME_CHARS = 7,
  parameter int unsigned CNT_W          = $clog2(MAX_NAME_CHARS + 2),
  parameter int unsigned ENTRY_W        = MAX_NAME_CHARS*8 + CNT_W + OFFSET_BITS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 valid_i,
  input  wire logic [ENTRY_W-1:0]                   entry_i,
  output logic                                      pop_o,
  output logic                                      res_valid_o,
  input  wire logic                                 res_ready_i,
  output logic [idls_pkg::OUT_OFFSET_W-1:0]         res_offset_o,
  output logic [idls_pkg::OUT_LEN_W-1:0]            res_len_o
);

  localparam int unsigned NAME_W = MAX_NAME_CHARS*8;
  localparam int unsigned OW     = idls_pkg::OUT_OFFSET_W;

  logic [NAME_W-1:0]      chars;
  logic [CNT_W-1:0]       count;
  logic [OFFSET_BITS-1:0] offset;
  logic                   name_ok;
  logic                   load;
  logic [OFFSET_BITS+OW-1:0] off_ext;
  logic                   out_valid_q, out_valid_d;
  logic [OW-1:0]          out_off_q;
  logic [idls_pkg::OUT_LEN_W-1:0] out_len_q, len_sat;

  assign {offset, count, chars} = entry_i;

  // Compare against every standard name in parallel
  always_comb begin
    name_ok = (count == '0);
    if (count <= CNT_W'(MAX_NAME_CHARS)) begin
      for (int k = 0; k < idls_pkg::NUM_DIRS; k++) begin
        if (chars[idls_pkg::DIR_CHARS*8-1:0] == idls_pkg::DIR_NAME[k] &&
            count == CNT_W'(idls_pkg::DIR_LEN[k])) begin
          name_ok = 1'b1;
        end
      end
    end
  end

  assign len_sat = (count >= CNT_W'(idls_pkg::LEN_SAT)) ?
                   idls_pkg::OUT_LEN_W'(idls_pkg::LEN_SAT) :
                   idls_pkg::OUT_LEN_W'(count);
  assign off_ext = {{OW{1'b0}}, offset};

  // Valid names are dropped; invalid ones wait for a free output slot
  assign pop_o       = valid_i && (name_ok || !out_valid_q || res_ready_i);
  assign load        = pop_o && !name_ok;
  assign out_valid_d = load ? 1'b1 : (res_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_off_q <= off_ext[OW-1:0];
      out_len_q <= len_sat;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_offset_o = out_off_q;
  assign res_len_o    = out_len_q;

endmodule

`default_nettype wire

// File: rtl/invalid_directive_line_scanner_top.sv
// ----------------------------------------------------------------------------
// invalid_directive_line_scanner_top
// Scans a skipped source region byte by byte and reports lines whose
// preprocessor directive name is not a standard one.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle with no gaps of its own: the scanner updates
// its line state for each byte, and a name that ends goes into a two-entry
// queue to the matcher, which judges one name per cycle and drops valid ones;
// an invalid one waits while the output register is full and not being read,
// then gives one transfer on the result side from that register. The input
// stalls only when the queue is full, that is when results are not being taken.
`default_nettype none

module invalid_directive_line_scanner_top #(
  parameter int unsigned OFFSET_BITS    = 24,
  parameter int unsigned MAX_NAME_CHARS = 7
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Byte input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  input  wire logic [1:0]  s_axis_tuser,   // [0] range_start, [1] spliced_before
  input  wire logic        s_axis_tlast,   // range_end
  // Result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [23:0] line_offset, [27:24] name_length
);

  localparam int unsigned CNT_W   = $clog2(MAX_NAME_CHARS + 2);
  localparam int unsigned ENTRY_W = MAX_NAME_CHARS*8 + CNT_W + OFFSET_BITS;

  logic               accept;
  logic               push, not_full, q_valid, pop;
  logic [ENTRY_W-1:0] push_entry, head_entry;
  logic [idls_pkg::OUT_OFFSET_W-1:0] res_offset;
  logic [idls_pkg::OUT_LEN_W-1:0]    res_len;

  assign s_axis_tready = not_full;
  assign accept        = s_axis_tvalid && not_full;

  // Front: byte scanner
  idls_front #(
    .OFFSET_BITS    (OFFSET_BITS),
    .MAX_NAME_CHARS (MAX_NAME_CHARS),
    .CNT_W          (CNT_W),
    .ENTRY_W        (ENTRY_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_i    (s_axis_tdata),
    .start_i   (s_axis_tuser[0]),
    .spliced_i (s_axis_tuser[1]),
    .end_i     (s_axis_tlast),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  // Judgment queue
  idls_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (push_entry),
    .not_full_o (not_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .data_o     (head_entry)
  );

  // Back: name matcher and output register
  idls_back #(
    .OFFSET_BITS    (OFFSET_BITS),
    .MAX_NAME_CHARS (MAX_NAME_CHARS),
    .CNT_W          (CNT_W),
    .ENTRY_W        (ENTRY_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .entry_i      (head_entry),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_offset_o (res_offset),
    .res_len_o    (res_len)
  );

  assign m_axis_tdata = {4'b0000, res_len, res_offset};

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the invalid directive line scanner. Source regions are
// built from directive lines, splices and noise and streamed a byte per
// transfer. A scoreboard tracks the line scan and predicts every offending
// directive, and each result transfer is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned RST_CYCLES  = 4;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned PHASE_BYTES = 80;
  localparam int unsigned NAME_KEEP   = 7;
  localparam logic [23:0] OFFSET_MAX  = 24'hFFFFFF;

  // Tracks the line scan and holds the directives expected to be flagged
  class directive_scoreboard;
    idls_pkg::scan_phase_e phase;
    bit          after_bsl;
    bit          after_bsl_cr;
    bit [55:0]   name_val;     // name bytes, last one in the low byte
    int unsigned name_cnt;
    bit [23:0]   line_start;
    bit [23:0]   next_pos;
    bit [27:0]   bad_lines[$]; // {name_length, line_offset}
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned bytes_seen;

    function new();
      mismatches   = 0;
      results_seen = 0;
      bytes_seen   = 0;
      restart(1'b0);
    endfunction

    function void restart(bit spliced);
      phase        = spliced ? idls_pkg::PH_SKIP_LINE : idls_pkg::PH_LINE_START;
      after_bsl    = 1'b0;
      after_bsl_cr = 1'b0;
      name_val     = '0;
      name_cnt     = 0;
      line_start   = '0;
      next_pos     = '0;
    endfunction

    function bit is_blank(bit [7:0] b);
      return b == idls_pkg::CH_SPACE || b == idls_pkg::CH_TAB;
    endfunction

    function bit is_name_byte(bit [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             b == idls_pkg::CH_UNDER;
    endfunction

    function bit [23:0] sat_next(bit [23:0] p);
      return (p == OFFSET_MAX) ? p : p + 24'd1;
    endfunction

    function void add_name_byte(bit [7:0] b);
      if (name_cnt < NAME_KEEP) name_val = {name_val[47:0], b};
      if (name_cnt < NAME_KEEP + 1) name_cnt++;
    endfunction

    // Judge the gathered name, queue a result when it is not standard
    function bit judge_name();
      bit bad;
      if (name_cnt == 0) bad = 1'b0;
      else if (name_cnt > NAME_KEEP) bad = 1'b1;
      else begin
        case (name_val)
          "if", "ifdef", "ifndef", "elif", "else", "endif", "include",
          "define", "undef", "line", "error", "pragma": bad = 1'b0;
          default: bad = 1'b1;
        endcase
      end
      if (bad) bad_lines.push_back({4'(name_cnt), line_start});
      return bad;
    endfunction

    // One accepted source byte
    function void note_byte(bit [7:0] b, bit first, bit spliced, bit last);
      bit        hit;
      bit [23:0] pos;
      hit = 1'b0;
      bytes_seen++;
      if (first) restart(spliced);
      pos = next_pos;
      case (phase)
        idls_pkg::PH_LINE_START: begin
          if (b == idls_pkg::CH_HASH) phase = idls_pkg::PH_AFTER_HASH;
          else if (!is_blank(b)) phase = idls_pkg::PH_SKIP_LINE;
        end
        idls_pkg::PH_AFTER_HASH: begin
          if (is_name_byte(b)) begin
            name_val = '0;
            name_cnt = 0;
            add_name_byte(b);
            phase = idls_pkg::PH_NAME;
          end else if (!is_blank(b)) begin
            phase = idls_pkg::PH_SKIP_LINE;
          end
        end
        idls_pkg::PH_NAME: begin
          if (is_name_byte(b)) add_name_byte(b);
          else begin
            hit = judge_name();
            phase = idls_pkg::PH_SKIP_LINE;
          end
        end
        default: phase = idls_pkg::PH_SKIP_LINE;
      endcase
      // newline: a spliced one keeps the next line skipped
      if (b == idls_pkg::CH_LF) begin
        phase = (after_bsl || after_bsl_cr) ? idls_pkg::PH_SKIP_LINE :
                                              idls_pkg::PH_LINE_START;
        line_start = sat_next(pos);
      end
      after_bsl_cr = after_bsl && b == idls_pkg::CH_CR;
      after_bsl    = b == idls_pkg::CH_BSL;
      next_pos     = sat_next(pos);
      if (last) begin
        if (phase == idls_pkg::PH_NAME && !hit) void'(judge_name());
        restart(1'b0);
      end
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // One accepted result transfer
    task check_result(bit [31:0] d);
      bit [27:0] exp;
      results_seen++;
      if (bad_lines.size() == 0) begin
        flag_mismatch($sformatf("unexpected result offset=%0d len=%0d", d[23:0], d[27:24]));
      end else begin
        exp = bad_lines.pop_front();
        if (d[23:0] != exp[23:0])
          flag_mismatch($sformatf("line_offset %0d, expected %0d", d[23:0], exp[23:0]));
        if (d[27:24] != exp[27:24])
          flag_mismatch($sformatf("name_length %0d, expected %0d", d[27:24], exp[27:24]));
      end
    endtask

    task check_drained();
      if (bad_lines.size() != 0)
        flag_mismatch($sformatf("%0d flagged lines never reported", bad_lines.size()));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  directive_scoreboard sb;
  bit [7:0]    region_q[$];
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req     = 1'b0;
  int unsigned bytes_sent   = 0;
  int unsigned regions_sent = 0;
  int unsigned quiet_cycles = 0;

  string dir_names[12] = '{"if", "ifdef", "ifndef", "elif", "else", "endif",
                           "include", "define", "undef", "line", "error", "pragma"};

  invalid_directive_line_scanner_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Transfer monitor on both sides
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic bit [7:0] rand_name_byte();
    int unsigned r;
    r = $urandom_range(52);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    return idls_pkg::CH_UNDER;
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) region_q.push_back(s[i]);
  endfunction

  function automatic void push_blank();
    region_q.push_back($urandom_range(1) ? idls_pkg::CH_SPACE : idls_pkg::CH_TAB);
  endfunction

  // One line: mostly a directive with a standard, near-miss or random name, sometimes noise
  function automatic void gen_line();
    int unsigned kind;
    int unsigned first;
    repeat ($urandom_range(2)) push_blank();
    if ($urandom_range(99) < 75) begin
      region_q.push_back(idls_pkg::CH_HASH);
      repeat ($urandom_range(2)) push_blank();
      kind  = $urandom_range(9);
      first = region_q.size();
      if (kind >= 1 && kind <= 6) push_text(dir_names[$urandom_range(11)]);
      else if (kind >= 7) repeat ($urandom_range(1, 10)) region_q.push_back(rand_name_byte());
      // near misses of standard names
      case (kind)
        4: void'(region_q.pop_back());
        5: region_q.push_back(rand_name_byte());
        6: region_q[first] = region_q[first] ^ 8'h20;
        default: ;
      endcase
      case ($urandom_range(3))
        1: push_blank();
        2: region_q.push_back(8'($urandom_range(255)));
        default: ;
      endcase
      repeat ($urandom_range(3)) region_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(6)) region_q.push_back(8'($urandom_range(255)));
    end
    // line end: plain, spliced, spliced with CR, CRLF or none
    case ($urandom_range(9))
      6: push_text("\\\n");
      7: begin
        region_q.push_back(idls_pkg::CH_BSL);
        region_q.push_back(idls_pkg::CH_CR);
        region_q.push_back(idls_pkg::CH_LF);
      end
      8: begin
        region_q.push_back(idls_pkg::CH_CR);
        region_q.push_back(idls_pkg::CH_LF);
      end
      9: ;
      default: region_q.push_back(idls_pkg::CH_LF);
    endcase
  endfunction

  task automatic send_byte(bit [7:0] b, bit first, bit spliced, bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {spliced, first};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Stream region_q; spliced_before is noise except on the opening byte
  task automatic send_region(bit open, bit spliced, bit close);
    int unsigned n;
    n = region_q.size();
    for (int unsigned i = 0; i < n; i++)
      send_byte(region_q[i], open && i == 0, (i == 0) ? spliced : 1'($urandom),
                close && i == n - 1);
    region_q.delete();
    regions_sent++;
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.bad_lines.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_base;
    sb = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Long name with no region start after reset
    push_text("#abcdefgh\n");
    send_region(1'b0, 1'b0, 1'b0);
    // Valid name after blanks, then the null directive
    push_text("# if\n#\n");
    send_region(1'b1, 1'b0, 1'b0);
    // Region continuing a splice: first line skipped, name cut by region end
    region_q.push_back(idls_pkg::CH_HASH);
    region_q.push_back(8'h00);
    region_q.push_back(8'hFF);
    region_q.push_back(idls_pkg::CH_LF);
    push_text("#Ab_");
    send_region(1'b1, 1'b1, 1'b1);
    // Backslash-CR-newline splice hides the directive
    region_q.push_back(idls_pkg::CH_BSL);
    region_q.push_back(idls_pkg::CH_CR);
    region_q.push_back(idls_pkg::CH_LF);
    push_text("#q");
    send_region(1'b1, 1'b0, 1'b1);
    wait_results();

    // Output held off while bad directives keep coming
    hold_req = 1'b1;
    repeat (10) begin
      region_q.push_back(idls_pkg::CH_HASH);
      region_q.push_back("q");
      region_q.push_back(rand_name_byte());
      region_q.push_back(idls_pkg::CH_LF);
    end
    send_region(1'b1, 1'b0, 1'b1);
    wait_results();

    // Random regions under four idle mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
        default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      phase_base = bytes_sent;
      while (bytes_sent - phase_base < PHASE_BYTES) begin
        repeat ($urandom_range(1, 5)) gen_line();
        send_region($urandom_range(99) < 90, $urandom_range(99) < 25,
                    $urandom_range(99) < 85);
      end
      wait_results();
    end

    sb.check_drained();
    $display("Streamed %0d bytes in %0d regions, %0d bad directives reported",
             sb.bytes_seen, regions_sent, sb.results_seen);
    $display("Covered splices, null and long names, near-miss names, region cuts, %s",
             "four idle mixes and a long output hold-off");
    if (sb.mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
